// ===== hdl/abba_pkg.sv =====
// shared types, constants and microcode program of the aligned bump allocator
package abba_pkg;

  localparam int SIZE_BITS  = 24;
  localparam int ALIGN_BITS = 12;
  localparam int ALIGN_W    = ALIGN_BITS + 1;
  localparam int CFG_W      = 24;
  localparam int SEQ_W      = 16;
  localparam int TOTAL_W    = 32;
  localparam int TYPE_W     = 3;
  localparam int CMP_W      = (SIZE_BITS > CFG_W) ? SIZE_BITS : CFG_W;
  localparam int SUM_W      = ((TOTAL_W > SIZE_BITS + 1) ? TOTAL_W : SIZE_BITS + 1) + 1;
  localparam int PC_W       = 5;

  localparam logic [CFG_W-1:0]   DEFAULT_BLOCK_RESET = CFG_W'(65536);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [ALIGN_W-1:0] ALIGN_MAX = ALIGN_W'(1) << ALIGN_BITS;

  localparam logic [TYPE_W-1:0] REQ_EXACT   = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] REQ_ATLEAST = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] REQ_PUTBACK = TYPE_W'(2);
  localparam logic [TYPE_W-1:0] REQ_RESET   = TYPE_W'(3);
  localparam logic [TYPE_W-1:0] REQ_UNMAP   = TYPE_W'(4);

  typedef struct packed {
    logic [TYPE_W-1:0]    req_type;
    logic [SIZE_BITS-1:0] request_bytes;
    logic [SIZE_BITS-1:0] fallback_bytes;
    logic [ALIGN_W-1:0]   align_bytes;
  } req_t;

  typedef struct packed {
    logic                  status;
    logic [SIZE_BITS-1:0]  start_offset;
    logic [SIZE_BITS-1:0]  granted_bytes;
    logic [ALIGN_BITS-1:0] pad_bytes;
    logic                  opened_block;
    logic [SEQ_W-1:0]      block_number;
    logic [TOTAL_W-1:0]    total_in_use;
  } rsp_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DIV_USED,
    OP_DIV_FREE,
    OP_PAD,
    OP_EXACT,
    OP_AL_PRE,
    OP_AL_POST,
    OP_PUTBACK,
    OP_CLEAR,
    OP_UNMAP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_INPUT,
    HOLD_DIV,
    HOLD_OUT
  } hold_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_TARGET,
    JMP_DISPATCH
  } jump_t;

  typedef struct packed {
    op_t   op;
    hold_t hold;
    jump_t jump;
    pc_t   target;
  } ucode_t;

  localparam pc_t S_WAIT     = PC_W'(0);
  localparam pc_t S_DISP     = PC_W'(1);
  localparam pc_t S_EX_DIV   = PC_W'(2);
  localparam pc_t S_EX_WAIT  = PC_W'(3);
  localparam pc_t S_EX_PAD   = PC_W'(4);
  localparam pc_t S_EX_TAKE  = PC_W'(5);
  localparam pc_t S_AL_DIV   = PC_W'(6);
  localparam pc_t S_AL_WAIT  = PC_W'(7);
  localparam pc_t S_AL_PAD   = PC_W'(8);
  localparam pc_t S_AL_PRE   = PC_W'(9);
  localparam pc_t S_AL_DIV2  = PC_W'(10);
  localparam pc_t S_AL_WAIT2 = PC_W'(11);
  localparam pc_t S_AL_POST  = PC_W'(12);
  localparam pc_t S_PB       = PC_W'(13);
  localparam pc_t S_RST      = PC_W'(14);
  localparam pc_t S_UNMAP    = PC_W'(15);
  localparam pc_t S_EMIT     = PC_W'(16);

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{op: OP_NONE, hold: HOLD_NONE, jump: JMP_NEXT, target: S_WAIT};
    unique case (pc)
      S_WAIT:     w = '{op: OP_LATCH,    hold: HOLD_INPUT, jump: JMP_NEXT,     target: S_WAIT};
      S_DISP:     w = '{op: OP_NONE,     hold: HOLD_NONE,  jump: JMP_DISPATCH, target: S_WAIT};
      S_EX_DIV:   w = '{op: OP_DIV_USED, hold: HOLD_NONE,  jump: JMP_NEXT,     target: S_WAIT};
      S_EX_WAIT:  w = '{op: OP_NONE,     hold: HOLD_DIV,   jump: JMP_NEXT,     target: S_WAIT};
      S_EX_PAD:   w = '{op: OP_PAD,      hold: HOLD_NONE,  jump: JMP_NEXT,     target: S_WAIT};
      S_EX_TAKE:  w = '{op: OP_EXACT,    hold: HOLD_NONE,  jump: JMP_TARGET,   target: S_EMIT};
      S_AL_DIV:   w = '{op: OP_DIV_USED, hold: HOLD_NONE,  jump: JMP_NEXT,     target: S_WAIT};
      S_AL_WAIT:  w = '{op: OP_NONE,     hold: HOLD_DIV,   jump: JMP_NEXT,     target: S_WAIT};
      S_AL_PAD:   w = '{op: OP_PAD,      hold: HOLD_NONE,  jump: JMP_NEXT,     target: S_WAIT};
      S_AL_PRE:   w = '{op: OP_AL_PRE,   hold: HOLD_NONE,  jump: JMP_NEXT,     target: S_WAIT};
      S_AL_DIV2:  w = '{op: OP_DIV_FREE, hold: HOLD_NONE,  jump: JMP_NEXT,     target: S_WAIT};
      S_AL_WAIT2: w = '{op: OP_NONE,     hold: HOLD_DIV,   jump: JMP_NEXT,     target: S_WAIT};
      S_AL_POST:  w = '{op: OP_AL_POST,  hold: HOLD_NONE,  jump: JMP_TARGET,   target: S_EMIT};
      S_PB:       w = '{op: OP_PUTBACK,  hold: HOLD_NONE,  jump: JMP_TARGET,   target: S_EMIT};
      S_RST:      w = '{op: OP_CLEAR,    hold: HOLD_NONE,  jump: JMP_TARGET,   target: S_EMIT};
      S_UNMAP:    w = '{op: OP_UNMAP,    hold: HOLD_NONE,  jump: JMP_TARGET,   target: S_EMIT};
      S_EMIT:     w = '{op: OP_EMIT,     hold: HOLD_OUT,   jump: JMP_TARGET,   target: S_WAIT};
      default:    w = '{op: OP_NONE,     hold: HOLD_NONE,  jump: JMP_TARGET,   target: S_WAIT};
    endcase
    return w;
  endfunction

  function automatic pc_t dispatch(input logic [TYPE_W-1:0] kind);
    pc_t t;
    t = S_EMIT;
    unique case (kind)
      REQ_EXACT:   t = S_EX_DIV;
      REQ_ATLEAST: t = S_AL_DIV;
      REQ_PUTBACK: t = S_PB;
      REQ_RESET:   t = S_RST;
      REQ_UNMAP:   t = S_UNMAP;
      default:     t = S_EMIT;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/abba_rem.sv =====
// bit-serial remainder unit: dividend modulo alignment, one quotient bit per cycle
module abba_rem import abba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SIZE_BITS-1:0]  dividend,
  input  logic [ALIGN_W-1:0]    divisor,
  output logic                  busy,
  output logic [ALIGN_BITS-1:0] rem
);

  localparam int CNT_W = $clog2(SIZE_BITS + 1);

  logic [CNT_W-1:0]     cnt;
  logic [SIZE_BITS-1:0] dvd;
  logic [ALIGN_W-1:0]   acc;
  logic [ALIGN_W-1:0]   dsr;
  logic [ALIGN_W:0]     shifted;
  logic                 ge;
  logic [ALIGN_W-1:0]   acc_next;

  assign shifted  = {acc, dvd[SIZE_BITS-1]};
  assign ge       = shifted >= {1'b0, dsr};
  assign acc_next = ge ? ALIGN_W'(shifted - {1'b0, dsr}) : shifted[ALIGN_W-1:0];
  assign busy     = cnt != '0;
  assign rem      = acc[ALIGN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(SIZE_BITS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      acc <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[SIZE_BITS-2:0], 1'b0};
      acc <= acc_next;
    end
  end

endmodule

// ===== hdl/aligned_bump_block_allocator.sv =====
// top level: microcoded aligned bump allocator over one open block
//
//   channel  direction  handshake         payload
//   in       to block   in_valid/in_stall  req_t (kind, bytes, fallback, align)
//   out      from block out_valid/out_stall rsp_t (status, range, block, total)
//   cfg      to block   cfg_we            cfg_wdata (default block bytes)
//
// exact alloc runs a modulo of the used bytes, at-least alloc also one of the
// free bytes; put back, reset and unmap run their own step, unknown kinds go
// to emit. the next transaction can be taken once the result is loaded. each
// modulo by the alignment holds the sequencer on the bit-serial remainder
// unit. rst clears the sequencer and allocator state and sets the default
// block size to its reset value. in_stall is high from acceptance until the
// result is loaded; a stalled result holds the sequencer at its emit step.
module aligned_bump_block_allocator import abba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  pc_t    pc;
  pc_t    pc_next;
  ucode_t uw;

  logic in_take;
  logic out_full;
  logic hold;

  logic [CFG_W-1:0]     dflt;
  logic [SIZE_BITS-1:0] cap;
  logic [SIZE_BITS-1:0] free;
  logic                 blk_open;
  logic [TOTAL_W-1:0]   total;
  logic [SEQ_W-1:0]     seq;

  logic [TYPE_W-1:0]     kind;
  logic [SIZE_BITS-1:0]  req;
  logic [SIZE_BITS-1:0]  fb;
  logic [ALIGN_W-1:0]    algn;
  logic [ALIGN_BITS-1:0] pad;

  logic                  r_status;
  logic [SIZE_BITS-1:0]  r_offset;
  logic [SIZE_BITS-1:0]  r_granted;
  logic [ALIGN_BITS-1:0] r_pad;
  logic                  r_opened;

  logic                  div_start;
  logic [SIZE_BITS-1:0]  div_dvd;
  logic                  div_busy;
  logic [ALIGN_BITS-1:0] div_rem;

  logic [ALIGN_W-1:0]    algn_in;
  logic [SIZE_BITS-1:0]  used;
  logic [SIZE_BITS:0]    pad_sum;
  logic                  fits;
  logic [SIZE_BITS-1:0]  cap_req;
  logic [SIZE_BITS-1:0]  cap_fb;
  logic [SIZE_BITS-1:0]  pb_n;
  logic                  pb_over;
  logic [SIZE_BITS-1:0]  free_pb;
  logic [ALIGN_BITS-1:0] pad_calc;
  logic [SIZE_BITS-1:0]  al_size;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] t,
                                                 input logic [SIZE_BITS:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(t) + SUM_W'(n);
    return (s > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] t,
                                                 input logic [SIZE_BITS-1:0] n);
    logic [SUM_W-1:0] d;
    d = SUM_W'(t) - SUM_W'(n);
    return (SUM_W'(n) >= SUM_W'(t)) ? '0 : d[TOTAL_W-1:0];
  endfunction

  function automatic logic [SIZE_BITS-1:0] max_cap(input logic [SIZE_BITS-1:0] want,
                                                   input logic [CFG_W-1:0] d);
    logic [CMP_W-1:0] m;
    m = (CMP_W'(want) > CMP_W'(d)) ? CMP_W'(want) : CMP_W'(d);
    return m[SIZE_BITS-1:0];
  endfunction

  abba_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (algn),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  assign uw       = ucode_rom(pc);
  assign in_stall = rst || (pc != S_WAIT);
  assign in_take  = in_valid && !in_stall;
  assign out_full = out_valid && out_stall;

  always_comb begin
    algn_in = in_data.align_bytes;
    if (algn_in == '0) begin
      algn_in = ALIGN_W'(1);
    end else if (algn_in > ALIGN_MAX) begin
      algn_in = ALIGN_MAX;
    end
  end

  assign used     = cap - free;
  assign pad_sum  = {1'b0, req} + (SIZE_BITS + 1)'(pad);
  assign fits     = blk_open && (pad_sum <= {1'b0, free});
  assign cap_req  = max_cap(req, dflt);
  assign cap_fb   = max_cap(fb, dflt);
  assign pb_over  = req > used;
  assign pb_n     = pb_over ? used : req;
  assign free_pb  = free + pb_n;
  assign pad_calc = (div_rem == '0) ? '0 : ALIGN_BITS'(algn - ALIGN_W'(div_rem));
  assign al_size  = free - SIZE_BITS'(div_rem);

  assign div_start = (uw.op == OP_DIV_USED) || (uw.op == OP_DIV_FREE);
  assign div_dvd   = (uw.op == OP_DIV_FREE) ? free : used;

  always_comb begin
    unique case (uw.hold)
      HOLD_INPUT: hold = !in_take;
      HOLD_DIV:   hold = div_busy;
      HOLD_OUT:   hold = out_full;
      default:    hold = 1'b0;
    endcase
    pc_next = pc + PC_W'(1);
    if (hold) begin
      pc_next = pc;
    end else begin
      unique case (uw.jump)
        JMP_TARGET:   pc_next = uw.target;
        JMP_DISPATCH: pc_next = dispatch(kind);
        default:      pc_next = pc + PC_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt <= DEFAULT_BLOCK_RESET;
    end else if (cfg_we) begin
      dflt <= cfg_wdata;
    end
  end

  // allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= '0;
      free     <= '0;
      blk_open <= 1'b0;
      total    <= '0;
      seq      <= '0;
    end else begin
      unique case (uw.op)
        OP_EXACT: begin
          if (fits) begin
            free  <= free - pad_sum[SIZE_BITS-1:0];
            total <= sat_add(total, pad_sum);
          end else begin
            cap      <= cap_req;
            free     <= cap_req - req;
            blk_open <= 1'b1;
            seq      <= seq + SEQ_W'(1);
            total    <= sat_add(total, {1'b0, req});
          end
        end
        OP_AL_PRE: begin
          if (!blk_open || (pad_sum > {1'b0, free})) begin
            cap      <= cap_fb;
            free     <= cap_fb;
            blk_open <= 1'b1;
            seq      <= seq + SEQ_W'(1);
          end else begin
            free  <= free - SIZE_BITS'(pad);
            total <= sat_add(total, (SIZE_BITS + 1)'(pad));
          end
        end
        OP_AL_POST: begin
          free  <= SIZE_BITS'(div_rem);
          total <= sat_add(total, {1'b0, al_size});
        end
        OP_PUTBACK: begin
          if (req != '0) begin
            total <= sat_sub(total, pb_n);
            if (free_pb == cap) begin
              blk_open <= 1'b0;
              cap      <= '0;
              free     <= '0;
            end else begin
              free <= free_pb;
            end
          end
        end
        OP_CLEAR: begin
          cap      <= '0;
          free     <= '0;
          blk_open <= 1'b0;
          total    <= '0;
          seq      <= '0;
        end
        OP_UNMAP: blk_open <= 1'b0;
        default: ;
      endcase
    end
  end

  // request latch and result fields
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_LATCH: begin
        if (in_take) begin
          kind      <= in_data.req_type;
          req       <= in_data.request_bytes;
          fb        <= in_data.fallback_bytes;
          algn      <= algn_in;
          r_status  <= 1'b0;
          r_offset  <= '0;
          r_granted <= '0;
          r_pad     <= '0;
          r_opened  <= 1'b0;
        end
      end
      OP_PAD: pad <= pad_calc;
      OP_EXACT: begin
        r_granted <= req;
        if (fits) begin
          r_offset <= used + SIZE_BITS'(pad);
          r_pad    <= pad;
        end else begin
          r_opened <= 1'b1;
        end
      end
      OP_AL_PRE: begin
        if (!blk_open || (pad_sum > {1'b0, free})) begin
          r_opened <= 1'b1;
          pad      <= '0;
        end else begin
          r_offset <= used + SIZE_BITS'(pad);
          r_pad    <= pad;
        end
      end
      OP_AL_POST: r_granted <= al_size;
      OP_PUTBACK: r_status <= (req != '0) && pb_over;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uw.op == OP_EMIT) && !out_full) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.op == OP_EMIT) && !out_full) begin
      out_data.status        <= r_status;
      out_data.start_offset  <= r_offset;
      out_data.granted_bytes <= r_granted;
      out_data.pad_bytes     <= r_pad;
      out_data.opened_block  <= r_opened;
      out_data.block_number  <= seq;
      out_data.total_in_use  <= total;
    end
  end

endmodule

// ===== hdl/abba_chk.sv =====
// port-level checker for the aligned bump allocator, bound to the top level
module abba_chk import abba_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rsp_t out_data
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("second transaction taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared in the cycle after acceptance");

  a_opened_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.opened_block |->
      (out_data.start_offset == '0) && (out_data.pad_bytes == '0))
    else $error("range in a new block not at offset zero");

endmodule

bind aligned_bump_block_allocator abba_chk u_chk (.*);
